// ===== rtl/upq_pkg.sv =====
// Shared types, codes and constants for the unsorted priority queue.
package upq_pkg;

    // Default number of key cells
    localparam int DefaultDepth = 16;

    // Width of the position field broadcast to the cells (covers up to 1024 cells)
    localparam int PosW = 10;

    // Key and result field widths
    localparam int KeyW   = 32;
    localparam int CountW = 5;

    // Request commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_LOAD   = 2'd1;
    localparam logic [1:0] CELL_SHIFT  = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic                   command;
        logic signed [KeyW-1:0] key_in;
    } upq_in_t;

    typedef struct packed {
        logic signed [KeyW-1:0] removed_key;
        logic signed [KeyW-1:0] current_min;
        logic [CountW-1:0]      entry_count;
        logic                   is_empty;
        logic [1:0]             status;
    } upq_out_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic [1:0]      op;
        logic [PosW-1:0] pos;
    } upq_cell_ctrl_t;

endpackage

// ===== rtl/upq_cell.sv =====
// One key cell of the chain: loads, compacts from its upper neighbor, or rotates.
module upq_cell #(
    parameter int IDX = 0
) (
    input  logic                           aclk,
    input  upq_pkg::upq_cell_ctrl_t        ctrl,
    input  logic signed [upq_pkg::KeyW-1:0] key_in,
    input  logic signed [upq_pkg::KeyW-1:0] next_key,
    output logic signed [upq_pkg::KeyW-1:0] key_out
);
    import upq_pkg::*;

    localparam logic [PosW-1:0] MyPos = PosW'(IDX);

    logic signed [KeyW-1:0] key_reg;
    logic signed [KeyW-1:0] key_next;

    // Select this cell's next key from the broadcast operation
    always_comb begin
        key_next = key_reg;
        case (ctrl.op)
            CELL_LOAD: begin
                if (ctrl.pos == MyPos) begin
                    key_next = key_in;
                end
            end
            CELL_SHIFT: begin
                if (MyPos >= ctrl.pos) begin
                    key_next = next_key;
                end
            end
            CELL_ROTATE: begin
                key_next = next_key;
            end
            default: begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;

endmodule

// ===== rtl/unsorted_priority_queue.sv =====
// Top level of the unsorted priority queue: sequencer, minimum tracker and the cell chain.
// Minimum priority queue of signed 32-bit keys held in a row of DEPTH cells in insertion
// order. An insert writes the key into the next free cell and updates the tracked minimum
// at once. A remove takes out the tracked
// minimum (the last of equal smallest keys), closes the gap by shifting the upper cells
// down one place, and then rotates the whole chain once around while a comparator at
// cell 0 looks at each held key to find the new minimum. Rejected requests (insert when
// full, remove when empty) go straight to the done state. One request is worked on at a
// time; the input is ready whenever the sequencer is idle, and a finished result waits in
// the output register until taken.
module unsorted_priority_queue #(
    parameter int DEPTH = upq_pkg::DefaultDepth
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  upq_pkg::upq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output upq_pkg::upq_out_t m_data
);
    import upq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic signed [KeyW-1:0] min_reg, min_next;
    logic [IW-1:0]          min_idx_reg, min_idx_next;
    logic [IW-1:0]          scan_k_reg, scan_k_next;
    logic signed [KeyW-1:0] removed_reg, removed_next;
    logic [1:0]             status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    upq_out_t               m_data_reg, m_data_next;

    upq_cell_ctrl_t         cell_ctrl;
    logic signed [KeyW-1:0] cell_key [DEPTH];
    logic signed [KeyW-1:0] head_key;

    logic                   s_fire;
    logic                   is_full;
    logic                   scan_last;
    logic [CW+CountW-1:0]   count_ext;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign scan_last = (scan_k_reg == IW'(DEPTH - 1));
    assign head_key  = cell_key[0];
    assign count_ext = {{CountW{1'b0}}, count_reg};

    // Build the chain of cells, each fed by its upper neighbor, the top one by cell 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        upq_cell #(
            .IDX(gi)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .key_in   (s_data.key_in),
            .next_key (cell_key[(gi + 1) % DEPTH]),
            .key_out  (cell_key[gi])
        );
    end

    // Sequence requests, drive the cells and track the minimum
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        scan_k_next  = scan_k_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.pos = '0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    removed_next = '0;
                    status_next  = ST_OK;
                    state_next   = S_DONE;
                    if (s_data.command == CMD_INSERT) begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            cell_ctrl.op  = CELL_LOAD;
                            cell_ctrl.pos = PosW'(count_reg);
                            count_next    = count_reg + CW'(1);
                            if ((count_reg == '0) || (s_data.key_in <= min_reg)) begin
                                min_next     = s_data.key_in;
                                min_idx_next = count_reg[IW-1:0];
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            cell_ctrl.op  = CELL_SHIFT;
                            cell_ctrl.pos = PosW'(min_idx_reg);
                            removed_next  = min_reg;
                            count_next    = count_reg - CW'(1);
                            scan_k_next   = '0;
                            state_next    = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Rotate the chain; cell 0 holds entry scan_k this cycle
                cell_ctrl.op = CELL_ROTATE;
                if (CW'(scan_k_reg) < count_reg) begin
                    if ((scan_k_reg == '0) || (head_key <= min_reg)) begin
                        min_next     = head_key;
                        min_idx_next = scan_k_reg;
                    end
                end
                scan_k_next = scan_k_reg + IW'(1);
                if (scan_last) begin
                    scan_k_next = '0;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                // Publish the result when the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.removed_key = removed_reg;
                    m_data_next.current_min = (count_reg == '0) ? '0 : min_reg;
                    m_data_next.entry_count = count_ext[CountW-1:0];
                    m_data_next.is_empty    = (count_reg == '0);
                    m_data_next.status      = status_reg;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            scan_k_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_k_reg  <= scan_k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Count never exceeds the cell count
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // A successful remove drops the count by one and starts the scan
    a_remove_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.command == CMD_REMOVE && count_reg != '0)
        |=> (state_reg == S_SCAN && count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not start scan");

    // A successful insert grows the count by one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.command == CMD_INSERT && !is_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

    // The scan ends after one full rotation
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && scan_last) |=> (state_reg == S_DONE))
        else $error("scan did not end after rotation");

endmodule

// ===== tb/unsorted_priority_queue_test.sv =====
// Self-checking testbench for the unsorted minimum priority queue.
module unsorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import upq_pkg::*;

    localparam int Depth  = DefaultDepth;
    localparam int MaxGap = 13;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     m_ready = 1'b0;
    upq_in_t  s_data  = '0;
    logic     s_ready;
    logic     m_valid;
    upq_out_t m_data;

    // Keys held by the predicted queue, in insertion order
    logic signed [KeyW-1:0] held_keys[$];
    // Results predicted for accepted requests, oldest first
    upq_out_t awaited_results[$];
    upq_out_t want_result;

    int gap_limit   = MaxGap;
    int stall_limit = MaxGap;
    int errors      = 0;
    int n_requests  = 0;
    int n_inserts   = 0;
    int n_removes   = 0;
    int n_dropped   = 0;
    int n_empty_rm  = 0;
    int peak_fill   = 0;

    always #4 aclk = ~aclk;

    unsorted_priority_queue #(
        .DEPTH(Depth)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Position of the last occurrence of the smallest held key
    function automatic int min_position();
        int best;
        best = 0;
        for (int i = 1; i < held_keys.size(); i++) begin
            if (!(held_keys[best] < held_keys[i])) begin
                best = i;
            end
        end
        return best;
    endfunction

    // Advance the predicted queue by one request and return the result it gives
    function automatic upq_out_t apply_request(upq_in_t req);
        upq_out_t res;
        int       p;
        res = '0;
        res.status = ST_OK;
        if (req.command == CMD_INSERT) begin
            if (held_keys.size() < Depth) begin
                held_keys.insert(held_keys.size(), req.key_in);
            end else begin
                res.status = ST_FULL;
            end
        end else if (held_keys.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            p = min_position();
            res.removed_key = held_keys[p];
            held_keys.delete(p);
        end
        if (held_keys.size() > 0) begin
            res.current_min = held_keys[min_position()];
        end
        res.entry_count = CountW'(held_keys.size());
        res.is_empty    = (held_keys.size() == 0);
        return res;
    endfunction

    // Mix of extremes, near-extremes, a narrow band for duplicates and full-range keys
    function automatic logic signed [KeyW-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return $signed(32'h8000_0000 + $urandom_range(0, 3));
            default: return $signed($urandom());
        endcase
    endfunction

    // Send one request after a random gap; predict its result once accepted
    task automatic send_request(input logic cmd, input logic signed [KeyW-1:0] key);
        int       gap;
        upq_out_t res;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.command = cmd;
        s_data.key_in  = key;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        res = apply_request(s_data);
        awaited_results.insert(awaited_results.size(), res);
        n_requests++;
        if (cmd == CMD_INSERT) n_inserts++;
        else n_removes++;
        if (res.status == ST_FULL) n_dropped++;
        if (res.status == ST_EMPTY) n_empty_rm++;
        if (held_keys.size() > peak_fill) peak_fill = held_keys.size();
        @(negedge aclk);
    endtask

    // Hold the sender off until every predicted result has come back
    task automatic wait_all_results();
        s_valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [KeyW-1:0] want,
                               input logic [KeyW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
            errors++;
        end
    endtask

    // Remove on empty, key extremes, equal smallest keys, fill up and overflow
    task automatic test_directed();
        send_request(CMD_REMOVE, 32'sh1234_5678);
        send_request(CMD_INSERT, 32'sh7FFF_FFFF);
        send_request(CMD_INSERT, 32'sh8000_0000);
        send_request(CMD_INSERT, 32'sh0000_0000);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sh8000_0000);
        send_request(CMD_INSERT, 32'sd1);
        send_request(CMD_REMOVE, -32'sd1);
        send_request(CMD_REMOVE, 32'sh0000_0000);
        send_request(CMD_REMOVE, 32'sh7FFF_FFFF);
        while (held_keys.size() < Depth) begin
            send_request(CMD_INSERT, pick_key());
        end
        // a new smallest key must not get in while full
        send_request(CMD_INSERT, 32'sh8000_0000);
    endtask

    // Random requests that swing the fill level between full and empty
    task automatic test_random_walk(input int count);
        int insert_pct;
        insert_pct = 25;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) insert_pct = (insert_pct == 75) ? 25 : 75;
            send_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                         pick_key());
        end
    endtask

    // Same traffic with neither side idling
    task automatic test_back_to_back(input int count);
        gap_limit   = 0;
        stall_limit = 0;
        test_random_walk(count);
        gap_limit   = MaxGap;
        stall_limit = MaxGap;
    endtask

    // Let the queue settle, drain it past empty, then refill at random
    task automatic test_drain_and_refill(input int count);
        int n;
        wait_all_results();
        n = held_keys.size() + 2;
        repeat (n) send_request(CMD_REMOVE, pick_key());
        test_random_walk(count);
    endtask

    // Drive result ready with a random stall before each result
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, stall_limit);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, got removed %0d min %0d count %0d",
                         $time, m_data.removed_key, m_data.current_min, m_data.entry_count);
                errors++;
            end else begin
                want_result = awaited_results.pop_front();
                check_field("removed_key", want_result.removed_key, m_data.removed_key);
                check_field("current_min", want_result.current_min, m_data.current_min);
                check_field("entry_count", KeyW'(want_result.entry_count),
                            KeyW'(m_data.entry_count));
                check_field("is_empty", KeyW'(want_result.is_empty), KeyW'(m_data.is_empty));
                check_field("status", KeyW'(want_result.status), KeyW'(m_data.status));
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_walk(400);
        test_back_to_back(150);
        test_drain_and_refill(200);

        // Wait out the last results, then a margin for stray ones
        s_valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (Depth + 8) @(posedge aclk);

        $display("Sent %0d requests: %0d inserts (%0d dropped when full), %0d removes",
                 n_requests, n_inserts, n_dropped, n_removes);
        $display("%0d removes hit an empty queue; fill level peaked at %0d of %0d",
                 n_empty_rm, peak_fill, Depth);
        if (errors == 0) begin
            $display("unsorted_priority_queue_test: clean");
        end else begin
            $display("unsorted_priority_queue_test: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("unsorted_priority_queue_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/upq_pkg.sv
rtl/upq_cell.sv
rtl/unsorted_priority_queue.sv
tb/unsorted_priority_queue_test.sv
